[rtl/wfrle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder package
// Shared constants, transaction payload types and the controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package wfrle_pkg;

   // Columns per row and rows per frame.
   localparam int IntensityLevels = 32;
   // Whole bytes (four phases each) that make one row.
   localparam int RowGroups = ((IntensityLevels / 4) < 1) ? 1 : (IntensityLevels / 4);
   // Rows reported for a single input transaction at most.
   localparam int MaxResults = 32;

   // Special byte codes of the waveform stream.
   localparam logic [7:0] ToggleByte = 8'hFC;
   localparam logic [7:0] StopByte   = 8'hFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_last;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] row_phases;
      logic [4:0]  row_index;
      logic        frame_done;
      logic [7:0]  frame_number;
      logic        run_last;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
   } wfrle_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic run_start;
      logic run_end;
      logic step_ok;
   } wfrle_sts_type;

endpackage

[rtl/wfrle_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder controller
// Two-state sequencer: takes one input transaction and, if it starts a run, steps the
// datapath through that run's row expansion one row per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module wfrle_ctrl
   import wfrle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  wfrle_sts_type sts,
   output wfrle_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Input is only taken while idle and out of reset.
   assign req_stall  = reset || (state_ff != S_IDLE);
   assign cmd.accept = req_valid && !req_stall;
   assign cmd.step   = (state_ff == S_RUN) && sts.step_ok;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && sts.run_start) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (cmd.step && sts.run_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/wfrle_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder datapath
// Byte decoding, run counter, row assembly, row and frame counters and the
// output register.
// ----------------------------------------------------------------------------
module wfrle_dpath
   import wfrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  wfrle_cmd_type   cmd,
   output wfrle_sts_type   sts,
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   // Decoder state.
   logic        repeat_on_ff, repeat_on_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        stopped_ff, stopped_in;
   // Row assembly state.
   logic [2:0]  group_column_ff, group_column_in;
   logic [4:0]  row_counter_ff, row_counter_in;
   logic [63:0] row_buffer_ff, row_buffer_in;
   logic [7:0]  frame_counter_ff, frame_counter_in;
   // Current run.
   logic [7:0]  run_byte_ff, run_byte_in;
   logic [8:0]  rem_ff, rem_in;
   logic        last_ff, last_in;
   logic [5:0]  rpt_ff, rpt_in;
   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       run_start;
   logic [7:0] start_byte;
   logic [8:0] start_reps;
   logic [3:0] need;
   logic       row_done;
   logic [8:0] rem_after;
   logic       run_end;
   logic       report;
   logic       frame_end;
   logic       run_last;
   logic [3:0] end_col;
   logic [7:0] fill;
   logic [63:0] filled;
   logic       clear;

   // Decide whether the incoming byte starts a run of placements.
   always_comb begin
      run_start  = 1'b0;
      start_byte = req_payload.data_byte;
      start_reps = 9'd1;
      if (stopped_ff) begin
         run_start = 1'b0;
      end else if (held_valid_ff) begin
         if (held_byte_ff != StopByte) begin
            run_start  = 1'b1;
            start_byte = held_byte_ff;
            start_reps = {1'b0, req_payload.data_byte} + 9'd1;
         end
      end else if (req_payload.data_byte == ToggleByte) begin
         run_start = 1'b0;
      end else if (repeat_on_ff && !req_payload.block_last) begin
         run_start = 1'b0;
      end else begin
         run_start = 1'b1;
      end
   end

   // One step fills the rest of the current row, or places the last partial groups.
   assign need      = 4'(RowGroups) - {1'b0, group_column_ff};
   assign row_done  = rem_ff >= {5'b0, need};
   assign rem_after = row_done ? (rem_ff - {5'b0, need}) : 9'd0;
   assign run_end   = !row_done || (rem_after == 9'd0);
   assign report    = rpt_ff < 6'(MaxResults);
   assign frame_end = ({1'b0, row_counter_ff} + 6'd1) >= 6'(IntensityLevels);
   assign run_last  = (rem_after < 9'(RowGroups)) || (rpt_ff == 6'(MaxResults - 1));
   assign end_col   = {1'b0, group_column_ff} + rem_ff[3:0];

   // Byte lanes written by this step.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         fill[i] = (i < RowGroups) && (4'(i) >= {1'b0, group_column_ff}) &&
                   (row_done || (4'(i) < end_col));
         filled[8*i +: 8] = row_buffer_ff[8*i +: 8] | (fill[i] ? run_byte_ff : 8'h00);
      end
   end

   assign sts.run_start = run_start;
   assign sts.run_end   = run_end;
   assign sts.step_ok   = !(row_done && report) || !rsp_valid_ff || !rsp_stall;

   // Next-state logic.
   always_comb begin
      repeat_on_in     = repeat_on_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      stopped_in       = stopped_ff;
      group_column_in  = group_column_ff;
      row_counter_in   = row_counter_ff;
      row_buffer_in    = row_buffer_ff;
      frame_counter_in = frame_counter_ff;
      run_byte_in      = run_byte_ff;
      rem_in           = rem_ff;
      last_in          = last_ff;
      rpt_in           = rpt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_payload_in   = rsp_payload_ff;
      clear            = 1'b0;

      // A new transaction updates the decoder and loads the run.
      if (cmd.accept) begin
         rpt_in      = 6'd0;
         last_in     = req_payload.block_last;
         run_byte_in = start_byte;
         rem_in      = start_reps;
         if (!stopped_ff) begin
            if (held_valid_ff) begin
               held_valid_in = 1'b0;
               if (held_byte_ff == StopByte) begin
                  stopped_in = 1'b1;
               end
            end else if (req_payload.data_byte == ToggleByte) begin
               repeat_on_in = !repeat_on_ff;
            end else if (repeat_on_ff && !req_payload.block_last) begin
               held_byte_in  = req_payload.data_byte;
               held_valid_in = 1'b1;
            end
         end
         if (req_payload.block_last && !run_start) begin
            clear = 1'b1;
         end
      end

      // One expansion step.
      if (cmd.step) begin
         if (row_done) begin
            rem_in          = rem_after;
            row_buffer_in   = 64'd0;
            group_column_in = 3'd0;
            if (frame_end) begin
               row_counter_in   = 5'd0;
               frame_counter_in = frame_counter_ff + 8'd1;
            end else begin
               row_counter_in = row_counter_ff + 5'd1;
            end
            if (report) begin
               rpt_in                      = rpt_ff + 6'd1;
               rsp_valid_in                = 1'b1;
               rsp_payload_in.row_phases   = filled;
               rsp_payload_in.row_index    = row_counter_ff;
               rsp_payload_in.frame_done   = frame_end;
               rsp_payload_in.frame_number = frame_counter_ff;
               rsp_payload_in.run_last     = run_last;
            end
         end else begin
            rem_in          = 9'd0;
            row_buffer_in   = filled;
            group_column_in = group_column_ff + rem_ff[2:0];
         end
         if (run_end && last_ff) begin
            clear = 1'b1;
         end
      end

      // End of block: back to the reset state, partial row and frame dropped.
      if (clear) begin
         repeat_on_in     = 1'b1;
         held_byte_in     = 8'd0;
         held_valid_in    = 1'b0;
         stopped_in       = 1'b0;
         group_column_in  = 3'd0;
         row_counter_in   = 5'd0;
         row_buffer_in    = 64'd0;
         frame_counter_in = 8'd0;
      end
   end

   // Control and decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_on_ff     <= 1'b1;
         held_byte_ff     <= 8'd0;
         held_valid_ff    <= 1'b0;
         stopped_ff       <= 1'b0;
         group_column_ff  <= 3'd0;
         row_counter_ff   <= 5'd0;
         row_buffer_ff    <= 64'd0;
         frame_counter_ff <= 8'd0;
         rem_ff           <= 9'd0;
         last_ff          <= 1'b0;
         rpt_ff           <= 6'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         repeat_on_ff     <= repeat_on_in;
         held_byte_ff     <= held_byte_in;
         held_valid_ff    <= held_valid_in;
         stopped_ff       <= stopped_in;
         group_column_ff  <= group_column_in;
         row_counter_ff   <= row_counter_in;
         row_buffer_ff    <= row_buffer_in;
         frame_counter_ff <= frame_counter_in;
         rem_ff           <= rem_in;
         last_ff          <= last_in;
         rpt_ff           <= rpt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      run_byte_ff    <= run_byte_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/waveform_phase_rle_decoder.sv]
`timescale 1ns / 1ps
// The first row caused by a byte is written to the output register by the first expansion
// step, which the sequencer makes once it has accepted that byte and entered its run state.
// A byte that places nothing is only accepted; any other byte is accepted and then takes one
// step per completed row and one for a trailing partial row, and a step that reports a row
// waits while the output holds a stalled row. No new byte is taken until the run is done.
// Reset is synchronous and active high and returns the decoder to repeat mode.
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder
// Expands run-length coded waveform bytes into rows of 2-bit drive phases.
// ----------------------------------------------------------------------------
module waveform_phase_rle_decoder
   import wfrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   wfrle_cmd_type cmd;
   wfrle_sts_type sts;

   // Sequencer.
   wfrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Decoder and row assembly.
   wfrle_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/wfrle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wfrle_checker
   import wfrle_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   // A stalled result transaction holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // The frame flag marks exactly the last row of a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.frame_done == (rsp_payload.row_index == 5'(IntensityLevels - 1))))
      else $error("frame flag and row index disagree");

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The input side only goes busy after taking a transaction.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stalled without a transaction");

endmodule

bind waveform_phase_rle_decoder wfrle_checker u_wfrle_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[verif/wfrle_row_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder row checker
// Watches the byte and row channels of the decoder. It keeps its own copy of
// the decoding state, works out the rows that each accepted byte should give
// and compares every accepted row, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module wfrle_row_checker
   import wfrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload,
   output int              mismatches,
   output int              rows_pending,
   output int              rows_checked,
   output int              frames_closed,
   output int              frame_peak
);

   // Decoding state, mirroring the block.
   logic        mode_repeat;
   logic [7:0]  run_byte;
   logic        run_held;
   logic [2:0]  byte_slot;
   logic [4:0]  row_number;
   logic [63:0] row_accum;
   logic [7:0]  frame_count;
   logic        block_halted;

   // Rows still to come from the decoder, oldest first.
   rsp_payload_type rows_due[$];

   int err_count = 0;
   int row_total = 0;
   int frame_total = 0;
   int peak_frame = 0;

   // Return to the state the decoder has after reset or at a block end.
   task automatic clear_decoder();
      mode_repeat  = 1'b1;
      run_byte     = 8'h00;
      run_held     = 1'b0;
      byte_slot    = 3'd0;
      row_number   = 5'd0;
      row_accum    = 64'd0;
      frame_count  = 8'd0;
      block_halted = 1'b0;
   endtask

   // Lay one byte of four phases into the row and queue the row once it is full.
   task automatic lay_byte(input logic [7:0] b, inout int produced);
      int              slot;
      logic            closing;
      rsp_payload_type row;
      row_accum = row_accum | ({56'd0, b} << (8 * byte_slot));
      slot = int'(byte_slot) + 1;
      if (slot >= RowGroups) begin
         closing = (int'(row_number) + 1) >= IntensityLevels;
         if (produced < MaxResults) begin
            row.row_phases   = row_accum;
            row.row_index    = row_number;
            row.frame_done   = closing;
            row.frame_number = frame_count;
            row.run_last     = 1'b0;
            rows_due = {rows_due, row};
            produced++;
         end
         row_accum = 64'd0;
         slot = 0;
         if (closing) begin
            row_number  = 5'd0;
            frame_count = frame_count + 8'd1;
         end else begin
            row_number = row_number + 5'd1;
         end
      end
      byte_slot = slot[2:0];
   endtask

   // Work out the rows caused by one accepted byte.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      int              produced;
      int              n;
      rsp_payload_type tail;
      produced = 0;
      if (block_halted) begin
         // Everything after the end marker is skipped until the block ends.
      end else if (run_held) begin
         // The byte after a held data byte is always its repeat count.
         run_held = 1'b0;
         if (run_byte == StopByte) begin
            block_halted = 1'b1;
         end else begin
            for (n = 0; n <= int'(b); n++) begin
               lay_byte(run_byte, produced);
            end
         end
      end else if (b == ToggleByte) begin
         mode_repeat = ~mode_repeat;
      end else if (mode_repeat && !last) begin
         run_byte = b;
         run_held = 1'b1;
      end else begin
         lay_byte(b, produced);
      end
      // The final row of this transaction carries the run end flag.
      if (produced > 0) begin
         tail = rows_due[rows_due.size() - 1];
         tail.run_last = 1'b1;
         rows_due[rows_due.size() - 1] = tail;
      end
      if (last) begin
         clear_decoder();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: row field %s wrong, expected %h, actual %h",
                  $time, name, want, got);
         err_count++;
      end
   endtask

   // Predict on accepted bytes first, then compare an accepted row with the
   // oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_decoder();
         rows_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_payload.data_byte, req_payload.block_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (rows_due.size() == 0) begin
               $display("%0t ns: unexpected row, expected none, actual %h",
                        $time, rsp_payload);
               err_count++;
            end else begin
               want = rows_due.pop_front();
               check_field("row_phases", want.row_phases, rsp_payload.row_phases);
               check_field("row_index", 64'(want.row_index), 64'(rsp_payload.row_index));
               check_field("frame_done", 64'(want.frame_done), 64'(rsp_payload.frame_done));
               check_field("frame_number", 64'(want.frame_number),
                           64'(rsp_payload.frame_number));
               check_field("run_last", 64'(want.run_last), 64'(rsp_payload.run_last));
               row_total++;
               if (want.frame_done) begin
                  frame_total++;
               end
               if (int'(want.frame_number) > peak_frame) begin
                  peak_frame = int'(want.frame_number);
               end
            end
         end
      end
      mismatches    <= err_count;
      rows_pending  <= rows_due.size();
      rows_checked  <= row_total;
      frames_closed <= frame_total;
      frame_peak    <= peak_frame;
   end

endmodule

[verif/tb_waveform_phase_rle_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform phase RLE decoder testbench
// Feeds directed and random waveform blocks into the decoder with random gaps
// on the byte channel and random stalls on the row channel. The row checker
// beside the decoder predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_waveform_phase_rle_decoder
   import wfrle_pkg::*;
();

   localparam int IdleLimit = 4000;
   localparam int RandomItems = 410;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   int mismatches;
   int rows_pending;
   int rows_checked;
   int frames_closed;
   int frame_peak;

   int  bytes_sent = 0;
   int  items_sent = 0;
   int  blocks_sent = 0;
   int  idle_cycles = 0;
   int  stall_hold = 0;
   int  stall_len = 0;
   bit  calm = 1'b0;

   // Sender's view of the decoder's mode, used to shape the stimulus.
   logic       gen_repeat = 1'b1;
   logic       gen_held = 1'b0;
   logic       gen_halted = 1'b0;
   logic [7:0] gen_held_byte = 8'h00;

   waveform_phase_rle_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   wfrle_row_checker u_row_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .mismatches    (mismatches),
      .rows_pending  (rows_pending),
      .rows_checked  (rows_checked),
      .frames_closed (frames_closed),
      .frame_peak    (frame_peak)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Idle gap length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 55) begin
         return 0;
      end else if (p < 85) begin
         return $urandom_range(1, 3);
      end else if (p < 96) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 50);
   endfunction

   // Repeat count: mostly short runs, some long, a few of the largest.
   function automatic logic [7:0] run_count();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) begin
         return 8'($urandom_range(0, 7));
      end else if (p < 80) begin
         return 8'($urandom_range(8, 63));
      end else if (p < 95) begin
         return 8'($urandom_range(64, 254));
      end
      return 8'hFF;
   endfunction

   // Follow the decoder's mode so that runs can be built on purpose.
   task automatic track_byte(input logic [7:0] b, input logic last);
      if (gen_halted) begin
      end else if (gen_held) begin
         gen_held = 1'b0;
         if (gen_held_byte == StopByte) begin
            gen_halted = 1'b1;
         end
      end else if (b == ToggleByte) begin
         gen_repeat = ~gen_repeat;
      end else if (gen_repeat && !last) begin
         gen_held = 1'b1;
         gen_held_byte = b;
      end
      if (last) begin
         gen_repeat = 1'b1;
         gen_held = 1'b0;
         gen_halted = 1'b0;
      end
   endtask

   // Send one byte transaction, starting and ending at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      track_byte(b, last);
      bytes_sent++;
      if (last) begin
         blocks_sent++;
      end
      @(negedge clock);
   endtask

   // One random block: runs, mode toggles, noise and perhaps an end marker.
   task automatic random_block(input int entries);
      int         e;
      int         pick;
      int         extra;
      logic [7:0] d;
      for (e = 0; e < entries && !gen_halted; e++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            d = 8'($urandom_range(0, 8'hFB));
            send_byte(d, 1'b0);
            if (gen_held) begin
               send_byte(run_count(), 1'b0);
            end
         end else if (pick < 80) begin
            send_byte(ToggleByte, 1'b0);
         end else if (pick < 94) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            if (gen_held) begin
               send_byte(run_count(), 1'b0);
            end
            if (!gen_repeat) begin
               send_byte(ToggleByte, 1'b0);
            end
            send_byte(StopByte, 1'b0);
            send_byte(run_count(), 1'b0);
            extra = $urandom_range(0, 4);
            repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      // Sometimes close the block on a count rather than on a data byte.
      if (!gen_halted && !gen_held && gen_repeat && $urandom_range(0, 2) == 0) begin
         send_byte(8'($urandom_range(0, 8'hFB)), 1'b0);
      end
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
         send_byte(ToggleByte, 1'b1);
      end else if (pick == 1) begin
         send_byte(StopByte, 1'b1);
      end else begin
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // Row channel stalls: alternate ready stretches and random stalls.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            stall_hold--;
         end else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(0, 8);
         end else begin
            stall_len = idle_gap();
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               stall_hold = stall_len - 1;
            end else begin
               stall_hold = $urandom_range(0, 8);
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A run of eight fills exactly one row; a count of zero places one byte.
      send_byte(8'h1B, 1'b0);
      send_byte(8'h07, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // Raw mode, where the stop byte is plain data.
      send_byte(ToggleByte, 1'b0);
      send_byte(8'hE4, 1'b0);
      send_byte(StopByte, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(ToggleByte, 1'b0);
      // Toggle and stop codes taken as repeat counts, the latter the largest run.
      send_byte(8'h55, 1'b0);
      send_byte(ToggleByte, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(StopByte, 1'b0);
      // End marker, after which bytes are skipped up to the block's last one.
      send_byte(StopByte, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(ToggleByte, 1'b0);
      send_byte(8'h42, 1'b1);
      // A whole frame from one run, then a count as the block's last byte.
      send_byte(8'h3C, 1'b0);
      send_byte(StopByte, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h01, 1'b1);
      // Last bytes in repeat mode: stop code, toggle code and plain data.
      send_byte(StopByte, 1'b1);
      send_byte(ToggleByte, 1'b1);
      send_byte(8'h81, 1'b1);
      // End marker whose count closes the block.
      send_byte(StopByte, 1'b0);
      send_byte(8'h00, 1'b1);

      // One long block of large runs drives the frame number up high.
      repeat (130) begin
         send_byte(8'($urandom_range(0, 8'hFB)), 1'b0);
         send_byte(($urandom_range(0, 9) == 0) ? run_count() : 8'hFF, 1'b0);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);

      // Random blocks, some of them without any idling.
      while (items_sent < RandomItems) begin
         calm = ($urandom_range(0, 5) == 0);
         random_block($urandom_range(2, 30));
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      wait (rows_pending == 0);
      repeat (40) @(posedge clock);

      $display("Sent %0d bytes in %0d blocks; compared %0d rows, %0d of them closing a frame.",
               bytes_sent, blocks_sent, rows_checked, frames_closed);
      $display("Highest frame number seen was %0d.", frame_peak);
      if (mismatches == 0 && rows_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
rtl/wfrle_pkg.sv
rtl/wfrle_ctrl.sv
rtl/wfrle_dpath.sv
rtl/waveform_phase_rle_decoder.sv
rtl/wfrle_checker.sv
verif/wfrle_row_checker.sv
verif/tb_waveform_phase_rle_decoder.sv
